// ===== sv/b2d_pkg.sv =====
// Shared constants and types for the binary to decimal digit converter.
`default_nettype none

package b2d_pkg;

  // Input width in bits and number of decimal digits kept.
  localparam int WIDTH      = 64;
  localparam int MAX_DIGITS = 20;

  localparam int DIGIT_W  = 4;
  localparam int BCD_W    = DIGIT_W * MAX_DIGITS;
  localparam int BCNT_W   = $clog2(WIDTH);
  localparam int DCNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int IN_TDATA_W  = ((WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DIGIT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Operands of one shift-add-3 step.
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic             shift_in;
  } step_in_t;

  // Result of one shift-add-3 step; carry is the bit lost off the top digit.
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic             carry;
  } step_out_t;

endpackage

`default_nettype wire

// ===== sv/b2d_dabble.sv =====
// Shift-add-3 step: doubles a BCD word and adds one binary bit.
`default_nettype none

module b2d_dabble (
  input  wire b2d_pkg::step_in_t  step_in,
  output b2d_pkg::step_out_t      step_out
);

  logic [b2d_pkg::BCD_W-1:0] adj;

  // Bump every digit of five or more by three so the shift carries in decimal.
  for (genvar i = 0; i < b2d_pkg::MAX_DIGITS; i++) begin : g_digit
    logic [b2d_pkg::DIGIT_W-1:0] d;
    assign d = step_in.bcd[b2d_pkg::DIGIT_W*i +: b2d_pkg::DIGIT_W];
    assign adj[b2d_pkg::DIGIT_W*i +: b2d_pkg::DIGIT_W] =
      (d >= 4'd5) ? d + 4'd3 : d;
  end

  assign step_out.bcd   = {adj[b2d_pkg::BCD_W-2:0], step_in.shift_in};
  assign step_out.carry = adj[b2d_pkg::BCD_W-1];

endmodule

`default_nettype wire

// ===== sv/binary_to_decimal_digits_core.sv =====
// Binary to decimal converter: one number in, its decimal digits out, most significant first.
// Each transaction on the input carries one unsigned number (low WIDTH bits used). The
// number passes through a shared shift-add-3 unit one bit per cycle; a digit sequencer
// then drops leading zeros and sends the digits one per cycle while the output is not
// stalled, with tlast on the least significant digit. The input is not ready until the
// last digit of a number has been handed to the output register. Zero gives the single
// digit 0. If a number has more than MAX_DIGITS digits, only its low MAX_DIGITS digits
// are sent, leading zeros included.
`default_nettype none

module binary_to_decimal_digits_core (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [b2d_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [63:0] value
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [b2d_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [3:0] digit, rest zero
  output logic                                m_axis_tlast
);

  b2d_pkg::state_t                 state, state_next;
  logic [b2d_pkg::WIDTH-1:0]       bin, bin_next;
  logic [b2d_pkg::BCD_W-1:0]       bcd, bcd_next;
  logic                            ovf, ovf_next;
  logic                            started, started_next;
  logic [b2d_pkg::BCNT_W-1:0]      bit_cnt, bit_cnt_next;
  logic [b2d_pkg::DCNT_W-1:0]      dig_left, dig_left_next;
  logic                            out_valid, out_valid_next;
  logic [b2d_pkg::DIGIT_W-1:0]     out_digit, out_digit_next;
  logic                            out_last, out_last_next;

  b2d_pkg::step_in_t               step_in;
  b2d_pkg::step_out_t              step_out;
  logic [b2d_pkg::DIGIT_W-1:0]     top_digit;
  logic                            out_free;
  logic                            in_xfer;
  logic                            out_load;

  b2d_dabble u_dabble (
    .step_in  (step_in),
    .step_out (step_out)
  );

  assign step_in.bcd      = bcd;
  assign step_in.shift_in = bin[b2d_pkg::WIDTH-1];

  assign top_digit = bcd[b2d_pkg::BCD_W-1 -: b2d_pkg::DIGIT_W];
  assign out_free  = !out_valid || m_axis_tready;
  assign in_xfer   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next     = state;
    bin_next       = bin;
    bcd_next       = bcd;
    ovf_next       = ovf;
    started_next   = started;
    bit_cnt_next   = bit_cnt;
    dig_left_next  = dig_left;
    out_valid_next = out_valid && !m_axis_tready;
    out_digit_next = out_digit;
    out_last_next  = out_last;
    s_axis_tready  = 1'b0;
    out_load       = 1'b0;

    case (state)
      b2d_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          bin_next     = s_axis_tdata[b2d_pkg::WIDTH-1:0];
          bcd_next     = '0;
          ovf_next     = 1'b0;
          started_next = 1'b0;
          bit_cnt_next = b2d_pkg::BCNT_W'(b2d_pkg::WIDTH - 1);
          state_next   = b2d_pkg::ST_CONV;
        end
      end
      b2d_pkg::ST_CONV: begin
        bcd_next = step_out.bcd;
        ovf_next = ovf || step_out.carry;
        bin_next = {bin[b2d_pkg::WIDTH-2:0], 1'b0};
        if (bit_cnt == '0) begin
          dig_left_next = b2d_pkg::DCNT_W'(b2d_pkg::MAX_DIGITS);
          state_next    = b2d_pkg::ST_EMIT;
        end else begin
          bit_cnt_next = bit_cnt - 1'b1;
        end
      end
      b2d_pkg::ST_EMIT: begin
        // Drop leading zeros unless the number overflowed the digit store.
        if (!started && !ovf && top_digit == '0 && dig_left != b2d_pkg::DCNT_W'(1)) begin
          bcd_next      = {bcd[b2d_pkg::BCD_W-b2d_pkg::DIGIT_W-1:0], {b2d_pkg::DIGIT_W{1'b0}}};
          dig_left_next = dig_left - 1'b1;
        end else if (out_free) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          out_digit_next = top_digit;
          out_last_next  = (dig_left == b2d_pkg::DCNT_W'(1));
          started_next   = 1'b1;
          bcd_next       = {bcd[b2d_pkg::BCD_W-b2d_pkg::DIGIT_W-1:0], {b2d_pkg::DIGIT_W{1'b0}}};
          dig_left_next  = dig_left - 1'b1;
          if (dig_left == b2d_pkg::DCNT_W'(1)) begin
            state_next = b2d_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = b2d_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= b2d_pkg::ST_IDLE;
      out_valid <= 1'b0;
      bit_cnt   <= '0;
      dig_left  <= '0;
      started   <= 1'b0;
      ovf       <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      bit_cnt   <= bit_cnt_next;
      dig_left  <= dig_left_next;
      started   <= started_next;
      ovf       <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    bin       <= bin_next;
    bcd       <= bcd_next;
    out_digit <= out_digit_next;
    out_last  <= out_last_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = b2d_pkg::OUT_TDATA_W'(out_digit);
  assign m_axis_tlast  = out_last;

`ifndef SYNTH
  a_start_conv: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == b2d_pkg::ST_CONV) &&
                (bit_cnt == b2d_pkg::BCNT_W'(b2d_pkg::WIDTH - 1)))
    else $error("conversion did not start after input transaction");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_load && out_last_next |=> state == b2d_pkg::ST_IDLE)
    else $error("sequencer did not return to idle after final digit");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == b2d_pkg::ST_EMIT |-> dig_left != '0)
    else $error("digit count ran out during emit");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_load |-> top_digit <= 4'd9)
    else $error("non-decimal digit loaded for output");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_binary_to_decimal_digits_core.sv =====
// Self-checking testbench for the binary to decimal digit converter.
`timescale 1ns / 100ps

module tb_binary_to_decimal_digits_core;

  localparam int U64_DIGITS  = 20;     // decimal digits of the largest 64-bit number
  localparam int STALL_LIMIT = 4000;   // cycles without any transaction
  localparam int RANDOM_ITEMS = 160;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [b2d_pkg::DIGIT_W-1:0] digit;
    logic                        last;
  } digit_item_t;

  class digit_scoreboard;
    digit_item_t expected_digits[$];
    int          errors;
    int          checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    // Split an accepted number into decimal digits, most significant first.
    function void note_number(logic [b2d_pkg::IN_TDATA_W-1:0] value);
      logic [63:0]                 quotient;
      logic [63:0]                 keep_mask;
      logic [b2d_pkg::DIGIT_W-1:0] low_first[$];
      int                          count;
      keep_mask = (b2d_pkg::WIDTH >= 64) ? '1 : ((64'd1 << b2d_pkg::WIDTH) - 64'd1);
      quotient  = value & keep_mask;
      count     = 0;
      do begin
        low_first.push_back(b2d_pkg::DIGIT_W'(quotient % 64'd10));
        quotient = quotient / 64'd10;
        count++;
      end while (quotient != 0 && count < b2d_pkg::MAX_DIGITS);
      for (int k = count - 1; k >= 0; k--)
        expected_digits.push_back('{digit: low_first[k], last: (k == 0)});
    endfunction

    function void check_digit(logic [b2d_pkg::DIGIT_W-1:0] digit, logic last);
      digit_item_t want;
      checked++;
      if (expected_digits.size() == 0) begin
        $error("unexpected digit %0d last %0b with nothing pending", digit, last);
        errors++;
        return;
      end
      want = expected_digits.pop_front();
      if (digit !== want.digit) begin
        $error("digit: expected %0d, actual %0d", want.digit, digit);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_digits.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [b2d_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;    // [63:0] value
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [b2d_pkg::OUT_TDATA_W-1:0] m_axis_tdata;         // [3:0] digit, rest zero
  logic                            m_axis_tlast;

  digit_scoreboard sb = new();
  bit              quiet = 1'b0;   // no gaps on either side while set
  int              idle_cycles = 0;

  binary_to_decimal_digits_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (quiet || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic logic [63:0] pow10(int n);
    logic [63:0] p;
    p = 64'd1;
    repeat (n) p = p * 64'd10;
    return p;
  endfunction

  // Full-range values, values of random bit length, and values of a chosen digit count.
  function automatic logic [63:0] random_number();
    logic [63:0] raw;
    logic [63:0] lo;
    logic [63:0] hi;
    int          kind;
    int          n;
    raw  = {$urandom, $urandom};
    kind = $urandom_range(9);
    if (kind < 3) return raw;
    if (kind < 5) return raw >> $urandom_range(63);
    n  = $urandom_range(1, U64_DIGITS);
    lo = (n == 1) ? 64'd0 : pow10(n - 1);
    hi = (n == U64_DIGITS) ? '1 : pow10(n) - 64'd1;
    return lo + raw % (hi - lo + 64'd1);
  endfunction

  task automatic send_number(input logic [63:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.note_number(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_digit(m_axis_tdata[b2d_pkg::DIGIT_W-1:0], m_axis_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : digit_sink
    int  run;
    int  hold;
    bit  pressure_done;
    pressure_done = 1'b0;
    @(negedge rst);
    forever begin
      // Hold off once for a long stretch so the converter backs up onto its input.
      if (!pressure_done && sb.checked >= 60) begin
        pressure_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      hold = pick_gap();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      run = $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [63:0] directed_values[$];
    directed_values = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd19, 64'd99, 64'd100, 64'd999, 64'd1000,
      64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
      64'd1000000000000000000, 64'd9999999999999999999, 64'd10000000000000000000,
      64'd12345678901234567890, 64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9000000000000000009
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_values[i])
      send_number(directed_values[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 70 && i < 100);
      send_number(random_number());
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
